// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of this block.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bqwd_pkg.sv =====
// Shared constants, types and register indexes of the biquad wet/dry core.
// No dependencies; used by the core, bqwd_serial_mul and bqwd_acc_round.
package bqwd_pkg;

  // Fixed widths
  localparam int COEF_W     = 32;
  localparam int ACC_W      = 64;
  localparam int CFG_IDX_W  = 3;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 26;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_A0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B2  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRY = 3'd6;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic clr;  // clear the accumulator
    logic add;  // add the finished product
    logic sub;  // negate the product before adding
  } acc_ctrl_t;

endpackage

// ===== hw/rtl/biquad_filter_wet_dry_core.sv =====
// Biquad IIR filter (direct form 1) with wet/dry mix; top level and sequencer.
// Depends on bqwd_pkg, bqwd_serial_mul and bqwd_acc_round.
//
// Usage:
//   Input stream s_axis_*: one signed sample per beat in tdata[SAMPLE_BITS-1:0].
//   Output stream m_axis_*: one filtered, rounded and saturated sample per beat.
//   Coefficients (Q6.26 by default) are written through cfg_we_i/cfg_idx_i/
//   cfg_data_i while the block is idle; indexes beyond the list are ignored.
//   Each sample needs seven products on one bit-serial multiplier, with a
//   rounding step after the five biquad products and another after the wet
//   and dry products. A new sample is accepted only when the sequencer is
//   idle again, that is once the previous result is in the output register.
//   The output register holds a finished sample until it is taken; the next
//   sample is accepted and worked on meanwhile, and only its final write
//   waits for the output register to free up.
//   Reset clears the history to zero and loads passthrough coefficients
//   (a0 = 1.0, wet = 1.0, all others zero).
module biquad_filter_wet_dry_core #(
  parameter int  SAMPLE_BITS    = bqwd_pkg::SAMPLE_BITS_DEF,
  parameter int  COEF_FRAC_BITS = bqwd_pkg::COEF_FRAC_BITS_DEF,
  localparam int TDATA_W        = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream; tdata: sample_in
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [TDATA_W-1:0]                s_axis_tdata_i,
  // output stream; tdata: sample_out
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [TDATA_W-1:0]                m_axis_tdata_o,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [bqwd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [bqwd_pkg::COEF_W-1:0]       cfg_data_i
);
  import bqwd_pkg::*;

  localparam logic signed [COEF_W-1:0] UNITY = COEF_W'(1) << COEF_FRAC_BITS;

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_RNDW  = 3'd3;
  localparam logic [2:0] ST_RNDY  = 3'd4;

  // Product steps
  localparam logic [2:0] STEP_A0  = 3'd0;
  localparam logic [2:0] STEP_A1  = 3'd1;
  localparam logic [2:0] STEP_A2  = 3'd2;
  localparam logic [2:0] STEP_B1  = 3'd3;
  localparam logic [2:0] STEP_B2  = 3'd4;
  localparam logic [2:0] STEP_DRY = 3'd5;
  localparam logic [2:0] STEP_WET = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] step_q, step_d;

  logic signed [COEF_W-1:0] a0_q, a1_q, a2_q, b1_q, b2_q, wet_q, dry_q;
  logic signed [SAMPLE_BITS-1:0] x_q, x1_q, x2_q, y1_q, y2_q;
  logic [SAMPLE_BITS-1:0] out_q;
  logic                   out_vld_q;

  logic                          in_acc, out_acc;
  logic signed [SAMPLE_BITS-1:0] op_smp;
  logic signed [COEF_W-1:0]      op_coef;
  logic                          op_sub;
  logic                          mul_start, mul_done;
  logic signed [ACC_W-1:0]       prod;
  logic signed [SAMPLE_BITS-1:0] res;
  acc_ctrl_t                     acc_ctrl;

  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  // Operand selection per product step
  always_comb begin
    op_smp  = x_q;
    op_coef = a0_q;
    op_sub  = 1'b0;
    case (step_q)
      STEP_A0:  begin op_smp = x_q;  op_coef = a0_q;  end
      STEP_A1:  begin op_smp = x1_q; op_coef = a1_q;  end
      STEP_A2:  begin op_smp = x2_q; op_coef = a2_q;  end
      STEP_B1:  begin op_smp = y1_q; op_coef = b1_q;  op_sub = 1'b1; end
      STEP_B2:  begin op_smp = y2_q; op_coef = b2_q;  op_sub = 1'b1; end
      STEP_DRY: begin op_smp = x_q;  op_coef = dry_q; end
      STEP_WET: begin op_smp = y1_q; op_coef = wet_q; end
      default:  begin op_smp = x_q;  op_coef = a0_q;  end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          state_d = ST_START;
          step_d  = STEP_A0;
        end
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (mul_done) begin
          if (step_q == STEP_B2) begin
            state_d = ST_RNDW;
          end else if (step_q == STEP_WET) begin
            state_d = ST_RNDY;
          end else begin
            state_d = ST_START;
            step_d  = step_q + 3'd1;
          end
        end
      end
      ST_RNDW: begin
        state_d = ST_START;
        step_d  = STEP_DRY;
      end
      ST_RNDY: begin
        if (!out_vld_q || m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign mul_start       = (state_q == ST_START);

  always_comb begin
    acc_ctrl.clr = in_acc || (state_q == ST_RNDW);
    acc_ctrl.add = (state_q == ST_WAIT) && mul_done;
    acc_ctrl.sub = op_sub;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= STEP_A0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a0_q  <= UNITY;
      a1_q  <= '0;
      a2_q  <= '0;
      b1_q  <= '0;
      b2_q  <= '0;
      wet_q <= UNITY;
      dry_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A0:  a0_q  <= cfg_data_i;
        REG_A1:  a1_q  <= cfg_data_i;
        REG_A2:  a2_q  <= cfg_data_i;
        REG_B1:  b1_q  <= cfg_data_i;
        REG_B2:  b2_q  <= cfg_data_i;
        REG_WET: wet_q <= cfg_data_i;
        REG_DRY: dry_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Filter history; shifts once the biquad output is known
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= '0;
      x2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (state_q == ST_RNDW) begin
      x2_q <= x1_q;
      x1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= res;
    end
  end

  // Current sample
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if ((state_q == ST_RNDY) && (!out_vld_q || m_axis_tready_i)) begin
      out_vld_q <= 1'b1;
    end else if (out_acc) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_RNDY) && (!out_vld_q || m_axis_tready_i)) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = TDATA_W'(out_q);

  bqwd_serial_mul #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (op_coef),
    .mplier_i (op_smp),
    .done_o   (mul_done),
    .prod_o   (prod)
  );

  bqwd_acc_round #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_acc (
    .clk_i  (clk_i),
    .ctrl_i (acc_ctrl),
    .prod_i (prod),
    .res_o  (res)
  );

endmodule

// ===== hw/rtl/bqwd_serial_mul.sv =====
// Bit-serial signed multiplier: sample bits shifted in LSB first, one per cycle.
// Depends on bqwd_pkg for the coefficient and accumulator widths.
module bqwd_serial_mul #(
  parameter int SAMPLE_BITS = bqwd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [bqwd_pkg::COEF_W-1:0]  mcand_i,
  input  logic signed [SAMPLE_BITS-1:0]       mplier_i,
  output logic                                done_o,
  output logic signed [bqwd_pkg::ACC_W-1:0]   prod_o
);
  import bqwd_pkg::*;

  localparam int HI_W  = COEF_W + 1;
  localparam int CNT_W = $clog2(SAMPLE_BITS);
  localparam int PRD_W = HI_W + SAMPLE_BITS;

  logic signed [COEF_W-1:0]  mcand_q;
  logic signed [HI_W-1:0]    hi_q, hi_d;
  logic [SAMPLE_BITS-1:0]    lo_q, lo_d;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q, done_q;
  logic                      last;
  logic signed [HI_W-1:0]    addend, sum;
  logic signed [PRD_W-1:0]   prod;

  assign last = (cnt_q == CNT_W'(SAMPLE_BITS - 1));

  // One add per bit; the sign bit of the sample carries negative weight
  always_comb begin
    addend = '0;
    if (lo_q[0]) begin
      addend = last ? -HI_W'(mcand_q) : HI_W'(mcand_q);
    end
    sum  = hi_q + addend;
    hi_d = {sum[HI_W-1], sum[HI_W-1:1]};
    lo_d = {sum[0], lo_q[SAMPLE_BITS-1:1]};
  end

  // Control: bit counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial product high word and shifted multiplier/low word
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign prod   = {hi_q, lo_q};
  assign prod_o = ACC_W'(prod);
  assign done_o = done_q;

endmodule

// ===== hw/rtl/bqwd_acc_round.sv =====
// Saturating 64-bit accumulator with round-half-up and saturation to sample width.
// Depends on bqwd_pkg for acc_ctrl_t and the accumulator width.
module bqwd_acc_round #(
  parameter int SAMPLE_BITS    = bqwd_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = bqwd_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  bqwd_pkg::acc_ctrl_t                ctrl_i,
  input  logic signed [bqwd_pkg::ACC_W-1:0]  prod_i,
  output logic signed [SAMPLE_BITS-1:0]      res_o
);
  import bqwd_pkg::*;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] OUT_MAX = (ACC_W'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - 1;

  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] term, rnd, shr;

  // Accumulate one product per request, saturating at the 64-bit limits
  always_comb begin
    term  = ctrl_i.sub ? -prod_i : prod_i;
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = sat_add(acc_q, term);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // Round half up, drop the fraction, clamp to the sample range
  always_comb begin
    rnd = sat_add(acc_q, HALF);
    shr = rnd >>> COEF_FRAC_BITS;
    if (shr > OUT_MAX) begin
      res_o = OUT_MAX[SAMPLE_BITS-1:0];
    end else if (shr < OUT_MIN) begin
      res_o = OUT_MIN[SAMPLE_BITS-1:0];
    end else begin
      res_o = shr[SAMPLE_BITS-1:0];
    end
  end

endmodule

// ===== hw/rtl/bqwd_checker.sv =====
// Port-level checker for the biquad wet/dry core, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bqwd_checker #(
  parameter int TDATA_W = 24
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tvalid_i,
  input logic               s_axis_tready_o,
  input logic [TDATA_W-1:0] s_axis_tdata_i,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o
);

  // A stalled output beat holds its value
  `ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "output beat changed while stalled")

  // After taking a sample the block is busy working on it
  `ASSERT_NEXT(a_busy_after_in, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input ready right after a beat")

  // Handshake outputs are always driven to known levels out of reset
  `ASSERT_CLK(a_hs_known, !$isunknown(s_axis_tready_o) && !$isunknown(m_axis_tvalid_o), "handshake output unknown")

endmodule

bind biquad_filter_wet_dry_core bqwd_checker #(.TDATA_W(TDATA_W)) u_bqwd_checker (.*);
